// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HGPC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HGPC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hgpc_pkg.sv =====
// types, constants and tables of the gait phase clock
`default_nettype none

package hgpc_pkg;

    localparam int unsigned LEG_COUNT     = 6;
    localparam int unsigned LEG_W         = 3;
    localparam int unsigned T_W           = 16;
    localparam int unsigned LAG_W         = 15;
    localparam int unsigned GAIT_W        = 2;
    localparam int unsigned CFG_ADDR_W    = 2;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned TICK_W        = 32;
    localparam int unsigned LAG_FRAC_BITS = 17;
    localparam int unsigned T12_W         = 20;
    localparam int unsigned SUM_W         = 21;
    localparam int unsigned SX_W          = 39;
    localparam int unsigned REM_W         = 38;
    localparam int unsigned STEP_W        = 6;
    localparam int unsigned MULT_W        = 5;
    localparam int unsigned GAP_W         = 4;

    localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(LEG_COUNT - 1);
    localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(TICK_W);
    localparam logic [T_W-1:0] CYCLE_TICKS_RESET = 16'd100;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CYCLE_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIT_MODE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_LAG   = 2'd2;

    // gait codes, any other code runs as tripod
    localparam logic [GAIT_W-1:0] GAIT_WAVE   = 2'd0;
    localparam logic [GAIT_W-1:0] GAIT_RIPPLE = 2'd1;
    localparam logic [GAIT_W-1:0] GAIT_TRIPOD = 2'd2;

    typedef struct packed {
        logic              walking;
        logic [TICK_W-1:0] t;
    } tick_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem_init;
        logic [TICK_W-1:0] dividend;
        logic [REM_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MOD,
        B_PREP,
        B_PREP2,
        B_SUM,
        B_WRAP,
        B_CLASS,
        B_CDIV,
        B_OUT
    } back_state_t;

    // 9 + twelfths-of-cycle offset of a leg, the 9 being the fixed 3T/4
    function automatic logic [MULT_W-1:0] leg_phase_mult(logic [GAIT_W-1:0] gait,
                                                         logic [LEG_W-1:0] leg);
        logic [2:0] slot;
        logic       half;
        case (leg)
            3'd0:    slot = 3'd0;
            3'd1:    slot = 3'd3;
            3'd2:    slot = 3'd4;
            3'd3:    slot = 3'd1;
            3'd4:    slot = 3'd2;
            3'd5:    slot = 3'd5;
            default: slot = 3'd0;
        endcase
        half = (leg == 3'd1) || (leg == 3'd2) || (leg == 3'd5);
        if (gait == GAIT_WAVE || gait == GAIT_RIPPLE) begin
            leg_phase_mult = 5'd9 + {1'b0, slot, 1'b0};
        end else begin
            leg_phase_mult = half ? 5'd15 : 5'd9;
        end
    endfunction

    // swing share of the cycle in twelfths
    function automatic logic [GAP_W-1:0] swing_twelfths(logic [GAIT_W-1:0] gait);
        case (gait)
            GAIT_WAVE:   swing_twelfths = 4'd2;
            GAIT_RIPPLE: swing_twelfths = 4'd4;
            default:     swing_twelfths = 4'd6;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hgpc_fifo.sv =====
// two-entry tick queue between front and back
`default_nettype none

module hgpc_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  hgpc_pkg::tick_t     push_data,
    input  wire                 pop,
    output hgpc_pkg::tick_t     pop_data,
    output logic                full,
    output logic                empty
);

    hgpc_pkg::tick_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule

`default_nettype wire

// ===== rtl/core/hgpc_front.sv =====
// input side: takes ticks and keeps the walking time counter
`default_nettype none

module hgpc_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_walking,
    input  wire                 q_full,
    output logic                q_push,
    output hgpc_pkg::tick_t     q_data
);

    logic                              was_walking_reg;
    logic                              was_walking_next;
    logic [hgpc_pkg::TICK_W-1:0]       elapsed_reg;
    logic [hgpc_pkg::TICK_W-1:0]       elapsed_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_data.walking   = s_walking;
        q_data.t         = '0;
        was_walking_next = was_walking_reg;
        elapsed_next     = elapsed_reg;
        if (q_push) begin
            was_walking_next = s_walking;
            if (!s_walking) begin
                elapsed_next = '0;
            end else if (!was_walking_reg) begin
                // first walking tick restarts time at zero
                elapsed_next = hgpc_pkg::TICK_W'(1);
            end else begin
                q_data.t     = elapsed_reg;
                elapsed_next = elapsed_reg + hgpc_pkg::TICK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_walking_reg <= 1'b0;
            elapsed_reg     <= '0;
        end else begin
            was_walking_reg <= was_walking_next;
            elapsed_reg     <= elapsed_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hgpc_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module hgpc_div #(
    parameter int unsigned QW = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  hgpc_pkg::div_req_t           req,
    output logic                         done,
    output logic [hgpc_pkg::REM_W-1:0]   rem,
    output logic [QW-1:0]                quo
);

    logic [hgpc_pkg::REM_W-1:0]  rem_reg;
    logic [hgpc_pkg::REM_W-1:0]  divisor_reg;
    logic [hgpc_pkg::TICK_W-1:0] dvd_reg;
    logic [QW-1:0]               quo_reg;
    logic [hgpc_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [hgpc_pkg::REM_W-1:0]  shifted;
    logic                        fits;

    // remainder stays below the divisor, so the top bit is free for the shift
    assign shifted = {rem_reg[hgpc_pkg::REM_W-2:0], dvd_reg[hgpc_pkg::TICK_W-1]};
    assign fits    = (shifted >= divisor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - hgpc_pkg::STEP_W'(1);
                if (cnt_reg == hgpc_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= req.rem_init;
            divisor_reg <= req.divisor;
            dvd_reg     <= req.dividend;
            quo_reg     <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? (shifted - divisor_reg) : shifted;
            dvd_reg <= {dvd_reg[hgpc_pkg::TICK_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hgpc_back.sv =====
// result side: phase and clock per leg, one leg at a time
`default_nettype none

module hgpc_back #(
    parameter int unsigned CLOCK_FRAC_BITS = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire [hgpc_pkg::T_W-1:0]          cycle_ticks,
    input  wire [hgpc_pkg::GAIT_W-1:0]       gait_mode,
    input  wire [hgpc_pkg::LAG_W-1:0]        phase_lag_frac,
    input  wire                              q_empty,
    input  hgpc_pkg::tick_t                  q_data,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [hgpc_pkg::LEG_W-1:0]       m_leg_index,
    output logic                             m_swing,
    output logic [CLOCK_FRAC_BITS:0]         m_leg_clock,
    output logic                             m_last_leg
);

    localparam int unsigned CW = CLOCK_FRAC_BITS + 1;
    localparam logic [CW-1:0] CLOCK_ONE = CW'(1) << CLOCK_FRAC_BITS;
    localparam int unsigned SX = hgpc_pkg::SX_W;
    localparam int unsigned LF = hgpc_pkg::LAG_FRAC_BITS;

    hgpc_pkg::back_state_t state_reg, state_next;

    logic                            walk_reg;
    logic [hgpc_pkg::LEG_W-1:0]      leg_reg;
    logic [hgpc_pkg::T12_W-1:0]      t12_reg;
    logic [hgpc_pkg::T12_W-1:0]      cyc12_reg;
    logic signed [SX-1:0]            h_reg, e_reg, full_reg;
    logic signed [SX-1:0]            b_reg, ep_reg, fh_reg, fe_reg;
    logic [hgpc_pkg::SUM_W-1:0]      sum_reg;
    logic signed [SX-1:0]            x_reg;
    logic                            swing_reg;
    logic [CW-1:0]                   clock_reg;
    logic                            m_valid_reg;
    logic [hgpc_pkg::LEG_W-1:0]      m_leg_reg;
    logic                            m_swing_reg;
    logic [CW-1:0]                   m_clock_reg;
    logic                            m_last_reg;

    logic [hgpc_pkg::T_W-1:0]        t_eff;
    logic [hgpc_pkg::T12_W-1:0]      r12;
    logic [hgpc_pkg::T12_W-1:0]      cyc12;
    logic [hgpc_pkg::T_W+hgpc_pkg::LAG_W-1:0] tl;
    logic [hgpc_pkg::T_W+hgpc_pkg::LAG_W+3:0] h_wide;
    logic [hgpc_pkg::T12_W-1:0]      gap_prod;
    logic [hgpc_pkg::SUM_W-1:0]      off_prod;
    logic [hgpc_pkg::SUM_W-1:0]      wrap1, wrap2;
    logic signed [SX-1:0]            num_swing, num_stance;
    logic                            out_free;
    logic                            load_out;
    logic                            div_start;
    hgpc_pkg::div_req_t              div_req;
    logic                            div_done;
    logic [hgpc_pkg::REM_W-1:0]      div_rem;
    logic [CLOCK_FRAC_BITS-1:0]      div_quo;

    hgpc_div #(
        .QW(CLOCK_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .done    (div_done),
        .rem     (div_rem),
        .quo     (div_quo)
    );

    // zero period runs as one tick
    assign t_eff = (cycle_ticks == '0) ? hgpc_pkg::T_W'(1) : cycle_ticks;

    assign r12   = {1'b0, div_rem[hgpc_pkg::T_W-1:0], 3'b000}
                 + {2'b00, div_rem[hgpc_pkg::T_W-1:0], 2'b00};
    assign cyc12 = {1'b0, t_eff, 3'b000} + {2'b00, t_eff, 2'b00};
    assign tl    = t_eff * phase_lag_frac;
    assign h_wide = {1'b0, tl, 3'b000} + {2'b00, tl, 2'b00};
    assign gap_prod = t_eff * hgpc_pkg::swing_twelfths(gait_mode);
    assign off_prod = t_eff * hgpc_pkg::leg_phase_mult(gait_mode, leg_reg);

    assign wrap1 = (sum_reg >= {1'b0, cyc12_reg}) ? (sum_reg - {1'b0, cyc12_reg}) : sum_reg;
    assign wrap2 = (wrap1 >= {1'b0, cyc12_reg}) ? (wrap1 - {1'b0, cyc12_reg}) : wrap1;

    assign num_swing  = x_reg - h_reg;
    assign num_stance = x_reg - e_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        div_start  = 1'b0;
        div_req    = '0;
        case (state_reg)
            hgpc_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_data.walking) begin
                        div_start        = 1'b1;
                        div_req.dividend = q_data.t;
                        div_req.divisor  = hgpc_pkg::REM_W'(t_eff);
                        div_req.steps    = hgpc_pkg::MOD_STEPS;
                        state_next       = hgpc_pkg::B_MOD;
                    end else begin
                        state_next = hgpc_pkg::B_OUT;
                    end
                end
            end
            hgpc_pkg::B_MOD: begin
                if (div_done) begin
                    state_next = hgpc_pkg::B_PREP;
                end
            end
            hgpc_pkg::B_PREP: begin
                state_next = hgpc_pkg::B_PREP2;
            end
            hgpc_pkg::B_PREP2: begin
                state_next = hgpc_pkg::B_SUM;
            end
            hgpc_pkg::B_SUM: begin
                state_next = hgpc_pkg::B_WRAP;
            end
            hgpc_pkg::B_WRAP: begin
                state_next = hgpc_pkg::B_CLASS;
            end
            hgpc_pkg::B_CLASS: begin
                state_next = hgpc_pkg::B_OUT;
                if (x_reg < h_reg) begin
                    state_next = hgpc_pkg::B_OUT;
                end else if (x_reg < b_reg) begin
                    div_start        = 1'b1;
                    div_req.rem_init = num_swing[hgpc_pkg::REM_W-1:0];
                    div_req.divisor  = b_reg[hgpc_pkg::REM_W-1:0];
                    div_req.steps    = hgpc_pkg::STEP_W'(CLOCK_FRAC_BITS);
                    state_next       = hgpc_pkg::B_CDIV;
                end else if (x_reg < ep_reg) begin
                    state_next = hgpc_pkg::B_OUT;
                end else if (x_reg < fh_reg) begin
                    div_start        = 1'b1;
                    div_req.rem_init = num_stance[hgpc_pkg::REM_W-1:0];
                    div_req.divisor  = fe_reg[hgpc_pkg::REM_W-1:0];
                    div_req.steps    = hgpc_pkg::STEP_W'(CLOCK_FRAC_BITS);
                    state_next       = hgpc_pkg::B_CDIV;
                end
            end
            hgpc_pkg::B_CDIV: begin
                if (div_done) begin
                    state_next = hgpc_pkg::B_OUT;
                end
            end
            hgpc_pkg::B_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (leg_reg == hgpc_pkg::LAST_LEG) begin
                        state_next = hgpc_pkg::B_IDLE;
                    end else if (walk_reg) begin
                        state_next = hgpc_pkg::B_SUM;
                    end else begin
                        state_next = hgpc_pkg::B_OUT;
                    end
                end
            end
            default: begin
                state_next = hgpc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hgpc_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            walk_reg  <= q_data.walking;
            leg_reg   <= '0;
            swing_reg <= 1'b0;
            clock_reg <= '0;
        end
        if (state_reg == hgpc_pkg::B_MOD && div_done) begin
            t12_reg <= r12;
        end
        if (state_reg == hgpc_pkg::B_PREP) begin
            cyc12_reg <= cyc12;
            h_reg     <= SX'(h_wide);
            e_reg     <= SX'({gap_prod, LF'(0)});
            full_reg  <= SX'({cyc12, LF'(0)});
        end
        if (state_reg == hgpc_pkg::B_PREP2) begin
            b_reg  <= e_reg - h_reg;
            ep_reg <= e_reg + h_reg;
            fh_reg <= full_reg - h_reg;
            fe_reg <= full_reg - e_reg;
        end
        if (state_reg == hgpc_pkg::B_SUM) begin
            sum_reg <= {1'b0, t12_reg} + off_prod;
        end
        if (state_reg == hgpc_pkg::B_WRAP) begin
            x_reg <= SX'({wrap2, LF'(0)});
        end
        if (state_reg == hgpc_pkg::B_CLASS) begin
            // swing lag, swing, lag into stance, stance, stance lag
            if (x_reg < h_reg) begin
                swing_reg <= 1'b1;
                clock_reg <= '0;
            end else if (x_reg < b_reg) begin
                swing_reg <= 1'b1;
            end else if (x_reg < ep_reg) begin
                swing_reg <= 1'b0;
                clock_reg <= '0;
            end else if (x_reg < fh_reg) begin
                swing_reg <= 1'b0;
            end else begin
                swing_reg <= 1'b0;
                clock_reg <= CLOCK_ONE;
            end
        end
        if (state_reg == hgpc_pkg::B_CDIV && div_done) begin
            clock_reg <= {1'b0, div_quo};
        end
        if (load_out) begin
            m_leg_reg   <= leg_reg;
            m_swing_reg <= swing_reg;
            m_clock_reg <= clock_reg;
            m_last_reg  <= (leg_reg == hgpc_pkg::LAST_LEG);
            leg_reg     <= leg_reg + hgpc_pkg::LEG_W'(1);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_leg_index = m_leg_reg;
    assign m_swing     = m_swing_reg;
    assign m_leg_clock = m_clock_reg;
    assign m_last_leg  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hexapod_gait_phase_clock.sv =====
// Hexapod gait phase clock, top level.
// Input stream: one item per gait tick, s_axis_tdata[0] is the walking flag.
// Output stream: six items per tick, legs 0 to 5 in order, tlast on leg 5.
// Each output item carries the leg number, swing/stance and a Q1.CLOCK_FRAC_BITS
// progress clock, where 1 << CLOCK_FRAC_BITS means a full phase.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 cycle period, 1 gait mode, 2 phase lag); write only while no tick is
// in flight.
// Timing: a walking tick first reduces its time count modulo the period on the
// shared serial divider, then each leg is worked in turn, using the same
// divider for its clock in the swing and stance spans. An idle tick skips
// the divider. The divider, used one bit per cycle, sets the pace of a
// walking tick.
// A two-entry queue lets ticks arrive while earlier ones are being worked.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// output, clears the time counter and loads the register reset values.
// A stalled receiver holds the current output item; work stops once the
// next result is ready, and input is refused only when the queue is full.
`default_nettype none

module hexapod_gait_phase_clock #(
    parameter int unsigned CLOCK_FRAC_BITS = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] walking
    input  wire [7:0]                             s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // [2:0] leg_index, [3] swing, [CLOCK_FRAC_BITS+4:4] leg_clock
    output logic [((CLOCK_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  wire                                   cfg_we,
    input  wire [hgpc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire [hgpc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int unsigned FIELD_W = hgpc_pkg::LEG_W + 1 + CLOCK_FRAC_BITS + 1;
    localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8;

    logic [hgpc_pkg::T_W-1:0]    cycle_ticks_reg;
    logic [hgpc_pkg::GAIT_W-1:0] gait_mode_reg;
    logic [hgpc_pkg::LAG_W-1:0]  phase_lag_reg;

    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    hgpc_pkg::tick_t             q_wdata;
    hgpc_pkg::tick_t             q_rdata;

    logic [hgpc_pkg::LEG_W-1:0]  leg_index;
    logic                        swing;
    logic [CLOCK_FRAC_BITS:0]    leg_clock;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_ticks_reg <= hgpc_pkg::CYCLE_TICKS_RESET;
            gait_mode_reg   <= hgpc_pkg::GAIT_WAVE;
            phase_lag_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                hgpc_pkg::CFG_CYCLE_TICKS: cycle_ticks_reg <= cfg_wdata;
                hgpc_pkg::CFG_GAIT_MODE:
                    gait_mode_reg <= cfg_wdata[hgpc_pkg::GAIT_W-1:0];
                hgpc_pkg::CFG_PHASE_LAG:
                    phase_lag_reg <= cfg_wdata[hgpc_pkg::LAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hgpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_walking (s_axis_tdata[0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    hgpc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    hgpc_back #(
        .CLOCK_FRAC_BITS(CLOCK_FRAC_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cycle_ticks    (cycle_ticks_reg),
        .gait_mode      (gait_mode_reg),
        .phase_lag_frac (phase_lag_reg),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_leg_index    (leg_index),
        .m_swing        (swing),
        .m_leg_clock    (leg_clock),
        .m_last_leg     (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'({leg_clock, swing, leg_index});

endmodule

`default_nettype wire

// ===== rtl/core/hgpc_checker.sv =====
// port-level checks on the gait phase clock, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module hgpc_checker #(
    parameter int unsigned CLOCK_FRAC_BITS = 16
) (
    input wire                                    aclk,
    input wire                                    aresetn,
    input wire                                    m_axis_tvalid,
    input wire                                    m_axis_tready,
    input wire [((CLOCK_FRAC_BITS+5+7)/8)*8-1:0]  m_axis_tdata,
    input wire                                    m_axis_tlast
);

    localparam logic [CLOCK_FRAC_BITS:0] CLOCK_ONE =
        (CLOCK_FRAC_BITS+1)'(1) << CLOCK_FRAC_BITS;

    logic [2:0]               leg;
    logic                     swing;
    logic [CLOCK_FRAC_BITS:0] clk_q;

    assign leg   = m_axis_tdata[2:0];
    assign swing = m_axis_tdata[3];
    assign clk_q = m_axis_tdata[CLOCK_FRAC_BITS+4:4];

    `HGPC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")
    `HGPC_ASSERT_IMP(a_leg_range, aclk, aresetn, m_axis_tvalid, leg <= 3'd5, "leg index out of range")
    `HGPC_ASSERT_IMP(a_last_leg, aclk, aresetn, m_axis_tvalid, m_axis_tlast == (leg == 3'd5), "tlast not on leg five")
    `HGPC_ASSERT_IMP(a_swing_clock, aclk, aresetn, m_axis_tvalid && swing, clk_q < CLOCK_ONE, "swing clock reached one")
    `HGPC_ASSERT_NXT(a_leg_order, aclk, aresetn, m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tvalid, !m_axis_tvalid || (leg == $past(leg) + 3'd1), "legs out of order")

endmodule

bind hexapod_gait_phase_clock hgpc_checker #(
    .CLOCK_FRAC_BITS(CLOCK_FRAC_BITS)
) u_hgpc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
